/* hw/rtl/bmp_rle_span_decoder_top_assert.svh */
// Assertion macros for the BMP RLE span decoder.
// Included by the top level; depends on nothing else.
`ifndef BMP_RLE_SPAN_DECODER_TOP_ASSERT_SVH
`define BMP_RLE_SPAN_DECODER_TOP_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define BRLE_ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);
// Next-cycle implication, disabled during reset.
`define BRLE_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);
`endif

/* hw/rtl/brle_pkg.sv */
// Shared types and codes of the BMP RLE span decoder.
// No dependencies; used by the front end, queue, back end and top level of the block.
package brle_pkg;

    localparam logic [1:0] REQ_PALETTE = 2'd0;
    localparam logic [1:0] REQ_DATA    = 2'd1;
    localparam logic [1:0] REQ_START   = 2'd2;

    localparam logic [1:0] KIND_SPAN = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] CMD_PAL   = 2'd3;

    localparam logic [1:0] REG_RLE_MODE     = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [2:0] PH_CODE0 = 3'd0;
    localparam logic [2:0] PH_CODE1 = 3'd1;
    localparam logic [2:0] PH_DX    = 3'd2;
    localparam logic [2:0] PH_DY    = 3'd3;
    localparam logic [2:0] PH_ABS   = 3'd4;
    localparam logic [2:0] PH_PAD   = 3'd5;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        rle_mode;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  idx_even;
        logic [7:0]  idx_odd;
        logic [23:0] rgb;
        logic [11:0] x;
        logic [11:0] row;
        logic [7:0]  len;
    } cmd_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       halted;
    } fstat_t;

endpackage

/* hw/rtl/brle_ifs.sv */
// Channel interfaces of the BMP RLE span decoder: requests, results, config writes.
// No dependencies.
interface brle_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  palette_index;
    logic [23:0] palette_rgb;
    logic [7:0]  data_byte;

    modport source (output valid, req_type, palette_index, palette_rgb, data_byte,
                    input ready);
    modport sink (input valid, req_type, palette_index, palette_rgb, data_byte,
                  output ready);
endinterface

interface brle_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [11:0] span_x;
    logic [11:0] span_row;
    logic [7:0]  span_length;
    logic [23:0] color_even;
    logic [23:0] color_odd;

    modport source (output valid, result_kind, span_x, span_row, span_length,
                    color_even, color_odd, input ready);
    modport sink (input valid, result_kind, span_x, span_row, span_length,
                  color_even, color_odd, output ready);
endinterface

interface brle_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/brle_front.sv */
// Front end: accepts requests, parses the RLE stream and tracks the cursor.
// Depends on brle_pkg and brle_ifs; emits palette writes and results as commands.
module brle_front
    import brle_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    brle_req_if.sink   req,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       cmd_push,
    output cmd_t       cmd,
    output fstat_t     stat
);

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int SW  = (CW > 8 ? CW : 8) + 1;
    localparam int RW2 = (RW > 8 ? RW : 8) + 1;

    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [7:0]    pend_reg, pend_next;
    logic [7:0]    abs_left_reg, abs_left_next;
    logic          pad_reg, pad_next;
    logic [7:0]    dcol_reg, dcol_next;
    logic          halted_reg, halted_next;

    logic          accept;
    logic [7:0]    b;
    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [SW-1:0] col_pend_sum, col_byte_sum, col_abs_sum, col_delta_sum;
    logic          row_ok, fits_pend, fits_byte;
    logic [RW:0]   row_inc;
    logic [RW-1:0] row_adv;
    logic [RW2-1:0] row_dsum;
    logic [RW-1:0] row_dy;
    logic [RW:0]   row_dy_inc;
    logic [RW-1:0] row_dy_adv;
    logic [RW-1:0] disp_row;
    logic [7:0]    abs_n;
    logic [7:0]    idx_hi, idx_lo;
    logic [8:0]    b_inc;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign b         = req.data_byte;
    assign stat      = '{phase: phase_reg, halted: halted_reg};

    assign eff_w = ({19'd0, cfg.image_width} > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                               : CW'(cfg.image_width);
    assign eff_h = ({19'd0, cfg.image_height} > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT)
                                                                 : RW'(cfg.image_height);

    assign col_pend_sum  = SW'(col_reg) + SW'(pend_reg);
    assign col_byte_sum  = SW'(col_reg) + SW'(b);
    assign col_abs_sum   = SW'(col_reg) + SW'(abs_n);
    assign col_delta_sum = SW'(col_reg) + SW'(dcol_reg);
    assign row_ok        = row_reg < eff_h;
    assign fits_pend     = row_ok && (col_pend_sum <= SW'(eff_w));
    assign fits_byte     = row_ok && (col_byte_sum <= SW'(eff_w));

    assign row_inc = {1'b0, row_reg} + (RW+1)'(1);
    assign row_adv = (row_inc >= {1'b0, eff_h}) ? eff_h : row_inc[RW-1:0];

    assign row_dsum   = RW2'(row_reg) + RW2'(b);
    assign row_dy     = (row_dsum >= RW2'(eff_h)) ? eff_h : RW'(row_dsum);
    assign row_dy_inc = {1'b0, row_dy} + (RW+1)'(1);
    assign row_dy_adv = (row_dy_inc >= {1'b0, eff_h}) ? eff_h : row_dy_inc[RW-1:0];

    assign disp_row = RW'(eff_h - row_reg - RW'(1));
    assign idx_hi   = {4'd0, b[7:4]};
    assign idx_lo   = {4'd0, b[3:0]};
    assign b_inc    = {1'b0, b} + 9'd1;

    always_comb
    begin
        if (abs_left_reg == 8'd0)
        begin
            abs_n = 8'd0;
        end
        else if (cfg.rle_mode && abs_left_reg >= 8'd2)
        begin
            abs_n = 8'd2;
        end
        else
        begin
            abs_n = 8'd1;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pend_next     = pend_reg;
        abs_left_next = abs_left_reg;
        pad_next      = pad_reg;
        dcol_next     = dcol_reg;
        halted_next   = halted_reg;
        cmd_push      = 1'b0;
        cmd           = '0;

        if (accept)
        begin
            case (req.req_type)
                REQ_PALETTE:
                begin
                    if ({24'd0, req.palette_index} < 32'(PALETTE_DEPTH))
                    begin
                        cmd_push     = 1'b1;
                        cmd.kind     = CMD_PAL;
                        cmd.idx_even = req.palette_index;
                        cmd.rgb      = req.palette_rgb;
                    end
                end
                REQ_START:
                begin
                    phase_next    = PH_CODE0;
                    col_next      = '0;
                    row_next      = '0;
                    pend_next     = '0;
                    abs_left_next = '0;
                    pad_next      = 1'b0;
                    dcol_next     = '0;
                    halted_next   = 1'b0;
                end
                REQ_DATA:
                begin
                    if (!halted_reg)
                    begin
                        case (phase_reg)
                            PH_CODE0:
                            begin
                                pend_next  = b;
                                phase_next = PH_CODE1;
                            end
                            PH_CODE1:
                            begin
                                phase_next = PH_CODE0;
                                if (pend_reg != 8'd0)
                                begin
                                    cmd_push = 1'b1;
                                    if (!fits_pend)
                                    begin
                                        cmd.kind    = KIND_ERR;
                                        halted_next = 1'b1;
                                    end
                                    else
                                    begin
                                        cmd.kind     = KIND_SPAN;
                                        cmd.x        = 12'(col_reg);
                                        cmd.row      = 12'(disp_row);
                                        cmd.len      = pend_reg;
                                        cmd.idx_even = cfg.rle_mode ? idx_hi : b;
                                        cmd.idx_odd  = cfg.rle_mode ? idx_lo : b;
                                        col_next     = CW'(col_pend_sum);
                                    end
                                end
                                else if (b == 8'd0)
                                begin
                                    col_next = '0;
                                    row_next = row_adv;
                                end
                                else if (b == 8'd1)
                                begin
                                    cmd_push    = 1'b1;
                                    cmd.kind    = KIND_END;
                                    halted_next = 1'b1;
                                end
                                else if (b == 8'd2)
                                begin
                                    phase_next = PH_DX;
                                end
                                else if (!fits_byte)
                                begin
                                    cmd_push    = 1'b1;
                                    cmd.kind    = KIND_ERR;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    abs_left_next = b;
                                    pad_next      = cfg.rle_mode ? b_inc[1] : b[0];
                                    phase_next    = PH_ABS;
                                end
                            end
                            PH_DX:
                            begin
                                dcol_next  = b;
                                phase_next = PH_DY;
                            end
                            PH_DY:
                            begin
                                phase_next = PH_CODE0;
                                if (col_delta_sum >= SW'(eff_w))
                                begin
                                    col_next = '0;
                                    row_next = row_dy_adv;
                                end
                                else
                                begin
                                    col_next = CW'(col_delta_sum);
                                    row_next = row_dy;
                                end
                            end
                            PH_ABS:
                            begin
                                abs_left_next = abs_left_reg - abs_n;
                                if (abs_left_reg == abs_n)
                                begin
                                    phase_next = pad_reg ? PH_PAD : PH_CODE0;
                                end
                                if (abs_n != 8'd0)
                                begin
                                    cmd_push     = 1'b1;
                                    cmd.kind     = KIND_SPAN;
                                    cmd.x        = 12'(col_reg);
                                    cmd.row      = 12'(disp_row);
                                    cmd.len      = abs_n;
                                    cmd.idx_even = cfg.rle_mode ? idx_hi : b;
                                    if (!cfg.rle_mode)
                                    begin
                                        cmd.idx_odd = b;
                                    end
                                    else if (abs_n == 8'd2)
                                    begin
                                        cmd.idx_odd = idx_lo;
                                    end
                                    else
                                    begin
                                        cmd.idx_odd = idx_hi;
                                    end
                                    col_next = CW'(col_abs_sum);
                                end
                            end
                            PH_PAD:
                            begin
                                pad_next   = 1'b0;
                                phase_next = PH_CODE0;
                            end
                            default:
                            begin
                                phase_next = PH_CODE0;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CODE0;
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= '0;
            abs_left_reg <= '0;
            pad_reg      <= 1'b0;
            dcol_reg     <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pend_reg     <= pend_next;
            abs_left_reg <= abs_left_next;
            pad_reg      <= pad_next;
            dcol_reg     <= dcol_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

/* hw/rtl/brle_queue.sv */
// Command queue between the parsing front end and the palette back end.
// Depends on brle_pkg for the command type and depth.
module brle_queue
    import brle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    localparam int QAW = $clog2(QUEUE_DEPTH);

    cmd_t           store [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = count_reg == (QAW+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = store[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/brle_back.sv */
// Back end: holds the palette, looks up span colors and drives the result channel.
// Depends on brle_pkg and brle_ifs; takes commands from brle_queue.
module brle_back
    import brle_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  cmd_t      q_data,
    output logic      q_pop,
    brle_res_if.source res
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [23:0]  palette [PALETTE_DEPTH];

    logic         s1_valid_reg;
    logic [1:0]   s1_kind_reg;
    logic [11:0]  s1_x_reg;
    logic [11:0]  s1_row_reg;
    logic [7:0]   s1_len_reg;
    logic         s1_zero_even_reg;
    logic         s1_zero_odd_reg;
    logic [23:0]  rd_even_reg;
    logic [23:0]  rd_odd_reg;

    logic         out_valid_reg;
    logic [1:0]   out_kind_reg;
    logic [11:0]  out_x_reg;
    logic [11:0]  out_row_reg;
    logic [7:0]   out_len_reg;
    logic [23:0]  out_even_reg;
    logic [23:0]  out_odd_reg;

    logic         out_free, s1_move, s1_free, s1_span;
    logic [23:0]  color_even_next, color_odd_next;

    assign out_free = !out_valid_reg || res.ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || s1_move;
    assign q_pop    = q_valid && s1_free;
    assign s1_span  = s1_kind_reg == KIND_SPAN;

    assign color_even_next = (s1_span && !s1_zero_even_reg) ? rd_even_reg : 24'd0;
    assign color_odd_next  = (s1_span && !s1_zero_odd_reg) ? rd_odd_reg : 24'd0;

    assign res.valid       = out_valid_reg;
    assign res.result_kind = out_kind_reg;
    assign res.span_x      = out_x_reg;
    assign res.span_row    = out_row_reg;
    assign res.span_length = out_len_reg;
    assign res.color_even  = out_even_reg;
    assign res.color_odd   = out_odd_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.kind == CMD_PAL)
        begin
            palette[q_data.idx_even[AW-1:0]] <= q_data.rgb;
        end
        if (q_pop)
        begin
            rd_even_reg <= palette[q_data.idx_even[AW-1:0]];
            rd_odd_reg  <= palette[q_data.idx_odd[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_kind_reg      <= q_data.kind;
            s1_x_reg         <= q_data.x;
            s1_row_reg       <= q_data.row;
            s1_len_reg       <= q_data.len;
            s1_zero_even_reg <= {24'd0, q_data.idx_even} >= 32'(PALETTE_DEPTH);
            s1_zero_odd_reg  <= {24'd0, q_data.idx_odd} >= 32'(PALETTE_DEPTH);
        end
        if (s1_move)
        begin
            out_kind_reg <= s1_kind_reg;
            out_x_reg    <= s1_x_reg;
            out_row_reg  <= s1_row_reg;
            out_len_reg  <= s1_len_reg;
            out_even_reg <= color_even_next;
            out_odd_reg  <= color_odd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= q_pop && (q_data.kind != CMD_PAL);
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/bmp_rle_span_decoder_top.sv */
// BMP RLE8/RLE4 span decoder top level: config registers, front end, queue, back end.
// Depends on brle_pkg, brle_ifs, brle_front, brle_queue, brle_back and the assert header.
//
// Usage: write palette entries (req_type 0), then a start request (req_type 2), then
// the compressed bytes (req_type 1) one per request. Each data byte yields at most
// one result: a pixel span, an end of image, or a decode error. Rows come out bottom-up,
// last row first. After an error or end of image, data bytes are dropped until a start.
// Channels: req (requests in), res (results out), cfg (register writes, index 0
// rle_mode, 1 image_width, 2 image_height; always ready, write only while idle).
// Throughput: one request per cycle while the command queue is not full, set by the
// parse loop in the front end and the palette lookup in the back end.
// Result path: a request's command is registered in the queue, then in the palette read
// register, then in the output register, where a stalled result channel holds it.
// A stalled result channel fills the 4-entry command queue, then req.ready drops.
// Reset: rle_mode 0, width and height 64, parser and cursor cleared, queue empty;
// the palette is not cleared and must be written before use.
module bmp_rle_span_decoder_top
    import brle_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    brle_req_if.sink   req,
    brle_res_if.source res,
    brle_cfg_if.sink   cfg
);

    `include "bmp_rle_span_decoder_top_assert.svh"

    logic        rle_mode_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic        cfg_write;

    cfg_t        cfg_cur;
    cmd_t        push_cmd, pop_cmd;
    logic        cmd_push, q_full, q_pop, q_valid;
    fstat_t      fstat;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign cfg_cur   = '{rle_mode: rle_mode_reg, image_width: image_width_reg,
                         image_height: image_height_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg     <= 1'b0;
            image_width_reg  <= 13'd64;
            image_height_reg <= 13'd64;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                REG_RLE_MODE:     rle_mode_reg     <= cfg.data[0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg.data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    brle_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg_cur),
        .q_full   (q_full),
        .cmd_push (cmd_push),
        .cmd      (push_cmd),
        .stat     (fstat)
    );

    brle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (pop_cmd)
    );

    brle_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (pop_cmd),
        .q_pop   (q_pop),
        .res     (res)
    );

    `BRLE_ASSERT_NEXT(a_start_clears, clk, rst_n,
        req.valid && req.ready && req.req_type == REQ_START,
        fstat.phase == PH_CODE0 && !fstat.halted,
        "start request did not clear the parser")
    `BRLE_ASSERT_SAME(a_halt_idle, clk, rst_n, fstat.halted,
        fstat.phase == PH_CODE0, "parser halted in the middle of a code")
    `BRLE_ASSERT_SAME(a_non_span_zero, clk, rst_n,
        res.valid && res.result_kind != KIND_SPAN,
        res.span_length == 8'd0 && res.color_even == 24'd0 && res.color_odd == 24'd0,
        "end or error result carries span data")
    `BRLE_ASSERT_SAME(a_span_nonempty, clk, rst_n,
        res.valid && res.result_kind == KIND_SPAN, res.span_length != 8'd0,
        "span result with zero length")

endmodule

/* bench/tb_bmp_rle_span_decoder_top.sv */
`timescale 1ns / 100ps
// Testbench for bmp_rle_span_decoder_top: directed and random RLE8/RLE4 streams, each span
// checked against an in-bench decoder; some random phases idle and stall both channels.
// Depends on brle_pkg, brle_ifs and the decoder RTL.
module tb_bmp_rle_span_decoder_top;
    import brle_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int PAL_DEPTH     = 256;
    localparam int RESET_SIZE    = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SEG_REQUESTS  = 100;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [7:0] RUN_ESCAPE = 8'd0;
    localparam logic [7:0] ESC_EOL    = 8'd0;
    localparam logic [7:0] ESC_END    = 8'd1;
    localparam logic [7:0] ESC_DELTA  = 8'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] x;
        logic [11:0] row;
        logic [7:0]  len;
        logic [23:0] color_even;
        logic [23:0] color_odd;
    } span_t;

    logic clk = 1'b0;
    logic rst_n;

    brle_req_if req_ch ();
    brle_res_if res_ch ();
    brle_cfg_if cfg_ch ();

    bmp_rle_span_decoder_top #(
        .MAX_WIDTH(MAX_W),
        .MAX_HEIGHT(MAX_H),
        .PALETTE_DEPTH(PAL_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .res(res_ch),
        .cfg(cfg_ch)
    );

    // decoder state
    logic        cfg_rle4;
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [23:0] palette [PAL_DEPTH];
    logic [2:0]  parse_state;
    logic [12:0] cur_col;
    logic [12:0] cur_row;
    logic [7:0]  run_count;
    logic [7:0]  abs_left;
    logic        pad_due;
    logic [7:0]  delta_x;
    logic        halted;

    span_t spans_due [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int requests_applied = 0;
    int requests_dropped = 0;
    int reg_writes = 0;
    int span_count = 0;
    int end_count = 0;
    int fault_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int eff_w();
        return (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
    endfunction

    function automatic int eff_h();
        return (cfg_height > MAX_H) ? MAX_H : int'(cfg_height);
    endfunction

    function automatic bit run_fits(input int len);
        return (int'(cur_row) < eff_h()) && (int'(cur_col) + len <= eff_w());
    endfunction

    task automatic advance_row();
        int h;
        h = eff_h();
        cur_row = 13'((int'(cur_row) + 1 >= h) ? h : int'(cur_row) + 1);
    endtask

    task automatic clear_image();
        parse_state = PH_CODE0;
        cur_col = '0;
        cur_row = '0;
        run_count = '0;
        abs_left = '0;
        pad_due = 1'b0;
        delta_x = '0;
        halted = 1'b0;
    endtask

    task automatic emit_result(input logic [1:0] kind, input int len,
                               input logic [23:0] ce, input logic [23:0] co);
        span_t s;
        s = '0;
        s.kind = kind;
        if (kind == KIND_SPAN)
        begin
            s.x = cur_col[11:0];
            s.row = 12'(eff_h() - 1 - int'(cur_row));
            s.len = 8'(len);
            s.color_even = ce;
            s.color_odd = co;
            cur_col = 13'(int'(cur_col) + len);
        end
        else
        begin
            halted = 1'b1;
            parse_state = PH_CODE0;
        end
        spans_due.push_back(s);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int r;
        int c;
        int n;
        logic [8:0] nbytes;
        logic [23:0] ce;
        logic [23:0] co;
        case (parse_state)
            PH_CODE0:
            begin
                run_count = b;
                parse_state = PH_CODE1;
            end
            PH_CODE1:
            begin
                parse_state = PH_CODE0;
                if (run_count != 0)
                begin
                    if (!run_fits(int'(run_count)))
                        emit_result(KIND_ERR, 0, '0, '0);
                    else if (cfg_rle4)
                        emit_result(KIND_SPAN, int'(run_count), palette[b[7:4]],
                                    palette[b[3:0]]);
                    else
                        emit_result(KIND_SPAN, int'(run_count), palette[b], palette[b]);
                end
                else if (b == ESC_EOL)
                begin
                    cur_col = '0;
                    advance_row();
                end
                else if (b == ESC_END)
                    emit_result(KIND_END, 0, '0, '0);
                else if (b == ESC_DELTA)
                    parse_state = PH_DX;
                else if (!run_fits(int'(b)))
                    emit_result(KIND_ERR, 0, '0, '0);
                else
                begin
                    nbytes = (9'(b) + 9'd1) >> 1;
                    abs_left = b;
                    pad_due = cfg_rle4 ? nbytes[0] : b[0];
                    parse_state = PH_ABS;
                end
            end
            PH_DX:
            begin
                delta_x = b;
                parse_state = PH_DY;
            end
            PH_DY:
            begin
                parse_state = PH_CODE0;
                r = int'(cur_row) + int'(b);
                cur_row = 13'((r >= eff_h()) ? eff_h() : r);
                c = int'(cur_col) + int'(delta_x);
                if (c >= eff_w())
                begin
                    cur_col = '0;
                    advance_row();
                end
                else
                    cur_col = 13'(c);
            end
            PH_ABS:
            begin
                if (cfg_rle4)
                begin
                    n = (abs_left >= 2) ? 2 : 1;
                    ce = palette[b[7:4]];
                    co = (n == 2) ? palette[b[3:0]] : ce;
                end
                else
                begin
                    n = 1;
                    ce = palette[b];
                    co = ce;
                end
                if (n > int'(abs_left))
                    n = int'(abs_left);
                abs_left = 8'(int'(abs_left) - n);
                if (abs_left == 0)
                    parse_state = pad_due ? PH_PAD : PH_CODE0;
                if (n != 0)
                    emit_result(KIND_SPAN, n, ce, co);
            end
            PH_PAD:
            begin
                pad_due = 1'b0;
                parse_state = PH_CODE0;
            end
            default: parse_state = PH_CODE0;
        endcase
    endtask

    task automatic decode_request(input logic [1:0] kind, input logic [7:0] idx,
                                  input logic [23:0] rgb, input logic [7:0] data,
                                  output logic applied);
        applied = 1'b1;
        case (kind)
            REQ_PALETTE: palette[idx] = rgb;
            REQ_START: clear_image();
            REQ_DATA:
                if (halted)
                    applied = 1'b0;
                else
                    decode_byte(data);
            default: applied = 1'b0;
        endcase
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [7:0] idx,
                                input logic [23:0] rgb, input logic [7:0] data);
        logic applied;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.palette_index <= idx;
        req_ch.palette_rgb <= rgb;
        req_ch.data_byte <= data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        decode_request(kind, idx, rgb, data, applied);
        if (applied)
            requests_applied++;
        else
            requests_dropped++;
        @(negedge clk);
    endtask

    task automatic send_data(input logic [7:0] b);
        send_request(REQ_DATA, 8'($urandom_range(0, 255)),
                     24'($urandom_range(0, 24'hFFFFFF)), b);
    endtask

    task automatic send_start();
        send_request(REQ_START, 8'($urandom_range(0, 255)),
                     24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 255)));
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [12:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_RLE_MODE: cfg_rle4 = value[0];
            REG_IMAGE_WIDTH: cfg_width = value;
            REG_IMAGE_HEIGHT: cfg_height = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // hold requests, drain results, then let the pipeline go quiet
    task automatic settle_results();
        int guard;
        req_ch.valid <= 1'b0;
        guard = 0;
        while (spans_due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (spans_due.size() != 0)
        begin
            $display("%0t: %0d results missing, expected kind %0d, actual none",
                     $time, spans_due.size(), spans_due[0].kind);
            fail_count += spans_due.size();
            spans_due.delete();
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        span_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (spans_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s %0d x %0d row %0d len %0d",
                         $time, "actual kind", res_ch.result_kind, res_ch.span_x,
                         res_ch.span_row, res_ch.span_length);
                fail_count++;
            end
            else
            begin
                want = spans_due.pop_front();
                check_field("result_kind", 24'(want.kind), 24'(res_ch.result_kind));
                check_field("span_x", 24'(want.x), 24'(res_ch.span_x));
                check_field("span_row", 24'(want.row), 24'(res_ch.span_row));
                check_field("span_length", 24'(want.len), 24'(res_ch.span_length));
                check_field("color_even", want.color_even, res_ch.color_even);
                check_field("color_odd", want.color_odd, res_ch.color_odd);
            end
            case (res_ch.result_kind)
                KIND_SPAN: span_count++;
                KIND_END: end_count++;
                KIND_ERR: fault_count++;
                default: ;
            endcase
        end
    end

    task automatic test_palette_load();
        logic [23:0] rgb;
        for (int i = 0; i < PAL_DEPTH; i++)
        begin
            if (i == 0)
                rgb = 24'h000000;
            else if (i == PAL_DEPTH - 1)
                rgb = 24'hFFFFFF;
            else
                rgb = 24'($urandom_range(0, 24'hFFFFFF));
            send_request(REQ_PALETTE, 8'(i), rgb, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_rle8_directed();
        settle_results();
        write_register(REG_RLE_MODE, 13'd0);
        write_register(REG_IMAGE_WIDTH, 13'd4096);
        write_register(REG_IMAGE_HEIGHT, 13'd2);
        send_start();
        send_data(8'd255);
        send_data(8'd255);
        // absolute run of three pixels, then its pad byte
        send_data(RUN_ESCAPE);
        send_data(8'd3);
        send_data(8'hFF);
        send_data(8'h80);
        send_data(8'h00);
        send_data(8'h00);
        // delta far past the bottom row
        send_data(RUN_ESCAPE);
        send_data(ESC_DELTA);
        send_data(8'hFF);
        send_data(8'hFF);
        // run below the last row fails and halts
        send_data(8'd1);
        send_data(8'h00);
        send_request(REQ_PALETTE, 8'h5A, 24'hA55A3C, 8'h00);
        send_data(8'd4);
        send_request(REQ_UNUSED, 8'hFF, 24'hFFFFFF, 8'hFF);
        send_start();
    endtask

    task automatic test_rle4_directed();
        settle_results();
        write_register(REG_RLE_MODE, 13'd1);
        write_register(REG_IMAGE_WIDTH, 13'd16);
        write_register(REG_IMAGE_HEIGHT, 13'd4);
        send_start();
        send_data(8'd5);
        send_data(8'hA5);
        // odd absolute run: lone last pixel, then pad
        send_data(RUN_ESCAPE);
        send_data(8'd5);
        send_data(8'h12);
        send_data(8'h34);
        send_data(8'h50);
        send_data(8'h00);
        // delta past the right edge wraps to the next row
        send_data(RUN_ESCAPE);
        send_data(ESC_DELTA);
        send_data(8'h0F);
        send_data(8'h00);
        send_data(8'd17);
        send_data(8'h77);
        send_start();
        send_data(RUN_ESCAPE);
        send_data(ESC_END);
    endtask

    task automatic test_mode_switch();
        settle_results();
        send_start();
        send_data(8'd4);
        settle_results();
        write_register(REG_RLE_MODE, 13'd0);
        send_data(8'h5A);
        send_data(RUN_ESCAPE);
        send_data(ESC_DELTA);
        settle_results();
        write_register(REG_RLE_MODE, 13'd1);
        send_data(8'd3);
        send_data(8'd0);
        send_data(RUN_ESCAPE);
        send_data(ESC_END);
    endtask

    task automatic test_random_streams();
        int seg;
        int seg_end;
        int room;
        int pick;
        int n;
        int w;
        int h;
        logic mode;
        logic paused;
        for (int p = 0; p < 4; p++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                settle_results();
                case (p)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                    default: begin send_idle_pct = 8; recv_stall_pct = 8; end
                endcase
                seg = 3 * p + s;
                if (seg % 4 == 0)
                begin
                    w = MAX_W;
                    h = MAX_H;
                    mode = 1'((seg / 4) % 2);
                end
                else if (seg % 4 == 1)
                begin
                    w = 1;
                    h = 1;
                    mode = 1'((seg / 4) % 2);
                end
                else
                begin
                    w = ($urandom_range(0, 3) == 0) ? MAX_W : int'($urandom_range(2, 600));
                    h = int'($urandom_range(1, 64));
                    mode = 1'($urandom_range(0, 1));
                end
                write_register(REG_RLE_MODE, 13'(mode));
                write_register(REG_IMAGE_WIDTH, 13'(w));
                write_register(REG_IMAGE_HEIGHT, 13'(h));
                send_start();
                seg_end = requests_applied + SEG_REQUESTS;
                paused = 1'b0;
                while (requests_applied < seg_end)
                begin
                    if (p == 2 && !paused && requests_applied >= seg_end - SEG_REQUESTS / 2)
                    begin
                        paused = 1'b1;
                        settle_results();
                    end
                    room = (int'(cur_row) < eff_h()) ? eff_w() - int'(cur_col) : 0;
                    if (room < 0)
                        room = 0;
                    pick = int'($urandom_range(0, 99));
                    if (halted)
                    begin
                        if (pick < 85)
                            send_start();
                        else
                            send_data(8'($urandom_range(0, 255)));
                    end
                    else if (int'(cur_row) >= eff_h() && pick < 70)
                        send_start();
                    else if (pick < 35)
                    begin
                        if (room > 0 && $urandom_range(0, 9) != 0)
                            n = int'($urandom_range(1, (room < 255) ? room : 255));
                        else
                            n = int'($urandom_range(1, 255));
                        send_data(8'(n));
                        send_data(8'($urandom_range(0, 255)));
                    end
                    else if (pick < 55)
                    begin
                        if (room >= 3 && $urandom_range(0, 9) != 0)
                            n = int'($urandom_range(3, (room < 40) ? room : 40));
                        else
                            n = int'($urandom_range(3, 255));
                        send_data(RUN_ESCAPE);
                        send_data(8'(n));
                        while (!halted && parse_state == PH_ABS)
                            send_data(8'($urandom_range(0, 255)));
                        if (!halted && parse_state == PH_PAD)
                            send_data(8'($urandom_range(0, 255)));
                    end
                    else if (pick < 65)
                    begin
                        send_data(RUN_ESCAPE);
                        send_data(ESC_EOL);
                    end
                    else if (pick < 73)
                    begin
                        send_data(RUN_ESCAPE);
                        send_data(ESC_DELTA);
                        send_data(8'($urandom_range(0, 255)));
                        if ($urandom_range(0, 19) == 0)
                            send_data(8'($urandom_range(0, 255)));
                        else
                            send_data(8'($urandom_range(0, 2)));
                    end
                    else if (pick < 76)
                    begin
                        send_data(RUN_ESCAPE);
                        send_data(ESC_END);
                    end
                    else if (pick < 82)
                        send_request(REQ_PALETTE, 8'($urandom_range(0, 255)),
                                     24'($urandom_range(0, 24'hFFFFFF)),
                                     8'($urandom_range(0, 255)));
                    else if (pick < 85)
                        send_start();
                    else if (pick < 89)
                        send_request(REQ_UNUSED, 8'($urandom_range(0, 255)),
                                     24'($urandom_range(0, 24'hFFFFFF)),
                                     8'($urandom_range(0, 255)));
                    else
                        send_data(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PALETTE;
        req_ch.palette_index = '0;
        req_ch.palette_rgb = '0;
        req_ch.data_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_RLE_MODE;
        cfg_ch.data = '0;
        cfg_rle4 = 1'b0;
        cfg_width = 13'(RESET_SIZE);
        cfg_height = 13'(RESET_SIZE);
        clear_image();
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_palette_load();
        test_rle8_directed();
        test_rle4_directed();
        test_mode_switch();
        test_random_streams();
        settle_results();
        $display("Sent %0d decoded and %0d dropped requests over %0d register writes.",
                 requests_applied, requests_dropped, reg_writes);
        $display("Checked %0d spans, %0d end-of-image and %0d error results.",
                 span_count, end_count, fault_count);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* bmp_rle_span_decoder_top.f */
+incdir+hw/rtl
hw/rtl/brle_pkg.sv
hw/rtl/brle_ifs.sv
hw/rtl/brle_front.sv
hw/rtl/brle_queue.sv
hw/rtl/brle_back.sv
hw/rtl/bmp_rle_span_decoder_top.sv
bench/tb_bmp_rle_span_decoder_top.sv
